// ----- hw/rtl/tbs_pkg.sv -----
// Shared types, codes and constants for the trickle broadcast scheduler.
package tbs_pkg;

  localparam int CMD_W = 3;
  localparam int TIME_W = 32;
  localparam int LEN_W = 24;
  localparam int MIN_W = 20;
  localparam int SHORT_W = 16;
  localparam int CNT_W = 8;
  localparam int EVT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 64;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEW_STATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONSISTENT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INCONSISTENT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // Event codes
  localparam logic [EVT_W-1:0] EVT_NONE = 3'd0;
  localparam logic [EVT_W-1:0] EVT_INTERVAL = 3'd1;
  localparam logic [EVT_W-1:0] EVT_BURST_START = 3'd2;
  localparam logic [EVT_W-1:0] EVT_BURST_END = 3'd3;
  localparam logic [EVT_W-1:0] EVT_SUPPRESSED = 3'd4;
  localparam logic [EVT_W-1:0] EVT_SCHEDULED = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRICKLE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSMIT_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIC_GAP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 3'd6;

  // Register reset values
  localparam logic [MIN_W-1:0] RST_MIN_INTERVAL = 20'd8000;
  localparam logic [LEN_W-1:0] RST_MAX_INTERVAL = 24'd256000;
  localparam logic [SHORT_W-1:0] RST_BURST_LEN = 16'd2000;
  localparam logic [SHORT_W-1:0] RST_BASIC_GAP = 16'd2000;
  localparam logic [CNT_W-1:0] RST_SUPPRESS = 8'd1;

  localparam logic [TIME_W-1:0] JITTER_LOW = 32'd300;
  localparam logic [LEN_W-1:0] JITTER_SPAN = 24'd1201;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_END_BASIC,
    ACT_END_TRICKLE,
    ACT_DOUBLE,
    ACT_SUPPRESS,
    ACT_BURST,
    ACT_NEW_TRICKLE,
    ACT_NEW_BASIC,
    ACT_CONSIST,
    ACT_RESTART,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    logic latch_in;
    logic upd_len;
    logic div_start;
    logic apply;
    logic load_out;
    act_t act;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic packet_held;
    logic tx_en;
    logic trickle;
    logic bursting;
    logic awaiting;
    logic burst_due;
    logic tx_due;
    logic supp_hit;
    logic div_done;
  } dp_stat_t;

  function automatic logic [EVT_W-1:0] act_event(input act_t a);
    logic [EVT_W-1:0] e;
    case (a)
      ACT_END_BASIC, ACT_END_TRICKLE: e = EVT_BURST_END;
      ACT_DOUBLE, ACT_NEW_TRICKLE, ACT_RESTART: e = EVT_INTERVAL;
      ACT_SUPPRESS: e = EVT_SUPPRESSED;
      ACT_BURST: e = EVT_BURST_START;
      ACT_NEW_BASIC: e = EVT_SCHEDULED;
      default: e = EVT_NONE;
    endcase
    return e;
  endfunction

  function automatic logic act_uses_div(input act_t a);
    logic u;
    case (a)
      ACT_END_BASIC, ACT_DOUBLE, ACT_NEW_TRICKLE, ACT_RESTART: u = 1'b1;
      default: u = 1'b0;
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/tbs_mod.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
module tbs_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tbs_pkg::TIME_W-1:0]   dividend,
  input  logic [tbs_pkg::LEN_W-1:0]    divisor,
  output logic                         done,
  output logic [tbs_pkg::LEN_W-1:0]    remainder
);

  localparam logic [tbs_pkg::DIV_CNT_W-1:0] DIV_LAST =
    tbs_pkg::DIV_CNT_W'(tbs_pkg::DIV_STEPS - 1);

  logic                             busy;
  logic [tbs_pkg::DIV_CNT_W-1:0]    cnt;
  logic [tbs_pkg::TIME_W-1:0]       quo;
  logic [tbs_pkg::LEN_W-1:0]        rem;
  logic [tbs_pkg::LEN_W-1:0]        dsr;
  logic [tbs_pkg::LEN_W:0]          trial;
  logic [tbs_pkg::LEN_W+1:0]        diff;

  assign trial = {rem, quo[tbs_pkg::TIME_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      quo <= {quo[tbs_pkg::TIME_W-2:0], 1'b0};
      // keep the trial value when the subtraction would go negative
      if (!diff[tbs_pkg::LEN_W+1]) begin
        rem <= diff[tbs_pkg::LEN_W-1:0];
      end else begin
        rem <= trial[tbs_pkg::LEN_W-1:0];
      end
    end
  end

  // an empty range gives a zero offset
  assign remainder = (dsr == '0) ? '0 : rem;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    done && dsr != '0 |-> rem < dsr)
    else $error("remainder not below divisor");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("remainder unit did not start");
`endif

endmodule

// ----- hw/rtl/tbs_datapath.sv -----
// Scheduler datapath: registers, deadlines, interval arithmetic and result register.
module tbs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [tbs_pkg::CMD_W-1:0]       in_command,
  input  logic [tbs_pkg::TIME_W-1:0]      in_now,
  input  logic [tbs_pkg::TIME_W-1:0]      in_random,
  input  tbs_pkg::dp_cmd_t                dp_cmd,
  output tbs_pkg::dp_stat_t               dp_stat,
  output logic [tbs_pkg::EVT_W-1:0]       out_event,
  output logic [tbs_pkg::LEN_W-1:0]       out_interval,
  output logic [tbs_pkg::TIME_W-1:0]      out_next,
  output logic                            out_burst
);

  // configuration
  logic                            trickle_mode;
  logic                            transmit_enabled;
  logic [tbs_pkg::MIN_W-1:0]       min_interval;
  logic [tbs_pkg::LEN_W-1:0]       max_interval;
  logic [tbs_pkg::SHORT_W-1:0]     burst_length;
  logic [tbs_pkg::SHORT_W-1:0]     basic_gap;
  logic [tbs_pkg::CNT_W-1:0]       suppress_threshold;

  // latched item
  logic [tbs_pkg::CMD_W-1:0]       cmd_q;
  logic [tbs_pkg::TIME_W-1:0]      now_q;
  logic [tbs_pkg::TIME_W-1:0]      rnd_q;

  // scheduler state
  logic                            packet_held;
  logic                            bursting;
  logic                            awaiting;
  logic [tbs_pkg::LEN_W-1:0]       interval_len;
  logic [tbs_pkg::TIME_W-1:0]      interval_end;
  logic [tbs_pkg::TIME_W-1:0]      transmit_time;
  logic [tbs_pkg::TIME_W-1:0]      burst_end;
  logic [tbs_pkg::CNT_W-1:0]       consistent_count;

  logic [tbs_pkg::LEN_W:0]         dbl;
  logic [tbs_pkg::LEN_W-1:0]       dbl_lim;
  logic [tbs_pkg::LEN_W-1:0]       half;
  logic [tbs_pkg::LEN_W-1:0]       span;
  logic [tbs_pkg::LEN_W-1:0]       divisor;
  logic [tbs_pkg::LEN_W-1:0]       rem;
  logic                            div_done;
  logic [tbs_pkg::TIME_W-1:0]      burst_diff;
  logic [tbs_pkg::TIME_W-1:0]      tx_diff;
  logic [tbs_pkg::LEN_W-1:0]       min_ext;

  assign min_ext = {{(tbs_pkg::LEN_W-tbs_pkg::MIN_W){1'b0}}, min_interval};
  assign dbl     = {interval_len, 1'b0};
  assign dbl_lim = (dbl > {1'b0, max_interval}) ? max_interval : dbl[tbs_pkg::LEN_W-1:0];
  assign half    = {1'b0, interval_len[tbs_pkg::LEN_W-1:1]};
  assign span    = interval_len - half;
  assign divisor = (dp_cmd.act == tbs_pkg::ACT_END_BASIC) ? tbs_pkg::JITTER_SPAN : span;

  // due when now minus deadline lands in the lower half of the clock range
  assign burst_diff = now_q - burst_end;
  assign tx_diff    = now_q - transmit_time;

  assign dp_stat.cmd         = cmd_q;
  assign dp_stat.packet_held = packet_held;
  assign dp_stat.tx_en       = transmit_enabled;
  assign dp_stat.trickle     = trickle_mode;
  assign dp_stat.bursting    = bursting;
  assign dp_stat.awaiting    = awaiting;
  assign dp_stat.burst_due   = !burst_diff[tbs_pkg::TIME_W-1];
  assign dp_stat.tx_due      = !tx_diff[tbs_pkg::TIME_W-1];
  assign dp_stat.supp_hit    = consistent_count >= suppress_threshold;
  assign dp_stat.div_done    = div_done;

  tbs_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (dp_cmd.div_start),
    .dividend  (rnd_q),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trickle_mode       <= 1'b1;
      transmit_enabled   <= 1'b0;
      min_interval       <= tbs_pkg::RST_MIN_INTERVAL;
      max_interval       <= tbs_pkg::RST_MAX_INTERVAL;
      burst_length       <= tbs_pkg::RST_BURST_LEN;
      basic_gap          <= tbs_pkg::RST_BASIC_GAP;
      suppress_threshold <= tbs_pkg::RST_SUPPRESS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tbs_pkg::CFG_TRICKLE_MODE: trickle_mode <= cfg_data[0];
        tbs_pkg::CFG_TRANSMIT_EN:  transmit_enabled <= cfg_data[0];
        tbs_pkg::CFG_MIN_INTERVAL: min_interval <= cfg_data[tbs_pkg::MIN_W-1:0];
        tbs_pkg::CFG_MAX_INTERVAL: max_interval <= cfg_data[tbs_pkg::LEN_W-1:0];
        tbs_pkg::CFG_BURST_LEN:    burst_length <= cfg_data[tbs_pkg::SHORT_W-1:0];
        tbs_pkg::CFG_BASIC_GAP:    basic_gap <= cfg_data[tbs_pkg::SHORT_W-1:0];
        tbs_pkg::CFG_SUPPRESS:     suppress_threshold <= cfg_data[tbs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.latch_in) begin
      cmd_q <= in_command;
      now_q <= in_now;
      rnd_q <= in_random;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_held      <= 1'b0;
      bursting         <= 1'b0;
      awaiting         <= 1'b0;
      interval_len     <= {{(tbs_pkg::LEN_W-tbs_pkg::MIN_W){1'b0}}, tbs_pkg::RST_MIN_INTERVAL};
      interval_end     <= '0;
      transmit_time    <= '0;
      burst_end        <= '0;
      consistent_count <= '0;
    end else if (dp_cmd.upd_len) begin
      case (dp_cmd.act)
        tbs_pkg::ACT_DOUBLE: interval_len <= dbl_lim;
        tbs_pkg::ACT_NEW_TRICKLE, tbs_pkg::ACT_NEW_BASIC, tbs_pkg::ACT_RESTART:
          interval_len <= min_ext;
        default: ;
      endcase
    end else if (dp_cmd.apply) begin
      case (dp_cmd.act)
        tbs_pkg::ACT_END_BASIC: begin
          bursting      <= 1'b0;
          transmit_time <= now_q + {{(tbs_pkg::TIME_W-tbs_pkg::SHORT_W){1'b0}}, basic_gap}
                           + tbs_pkg::JITTER_LOW
                           + {{(tbs_pkg::TIME_W-tbs_pkg::LEN_W){1'b0}}, rem};
        end
        tbs_pkg::ACT_END_TRICKLE: begin
          bursting      <= 1'b0;
          awaiting      <= 1'b1;
          transmit_time <= interval_end;
        end
        tbs_pkg::ACT_DOUBLE, tbs_pkg::ACT_NEW_TRICKLE, tbs_pkg::ACT_RESTART: begin
          if (dp_cmd.act == tbs_pkg::ACT_NEW_TRICKLE) begin
            packet_held <= 1'b1;
          end
          interval_end     <= now_q + {{(tbs_pkg::TIME_W-tbs_pkg::LEN_W){1'b0}}, interval_len};
          transmit_time    <= now_q + {{(tbs_pkg::TIME_W-tbs_pkg::LEN_W){1'b0}}, half}
                              + {{(tbs_pkg::TIME_W-tbs_pkg::LEN_W){1'b0}}, rem};
          consistent_count <= '0;
          awaiting         <= 1'b0;
        end
        tbs_pkg::ACT_SUPPRESS: begin
          awaiting      <= 1'b1;
          transmit_time <= interval_end;
        end
        tbs_pkg::ACT_BURST: begin
          bursting  <= 1'b1;
          burst_end <= now_q + {{(tbs_pkg::TIME_W-tbs_pkg::SHORT_W){1'b0}}, burst_length};
        end
        tbs_pkg::ACT_NEW_BASIC: begin
          packet_held   <= 1'b1;
          transmit_time <= now_q;
          awaiting      <= 1'b0;
        end
        tbs_pkg::ACT_CONSIST: begin
          if (consistent_count != tbs_pkg::CNT_MAX) begin
            consistent_count <= consistent_count + 1'b1;
          end
        end
        tbs_pkg::ACT_CLEAR: begin
          packet_held      <= 1'b0;
          bursting         <= 1'b0;
          awaiting         <= 1'b0;
          interval_len     <= min_ext;
          interval_end     <= '0;
          transmit_time    <= '0;
          burst_end        <= '0;
          consistent_count <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load_out) begin
      out_event    <= tbs_pkg::act_event(dp_cmd.act);
      out_interval <= interval_len;
      out_next     <= transmit_time;
      out_burst    <= bursting;
    end
  end

endmodule

// ----- hw/rtl/tbs_ctrl.sv -----
// Scheduler controller: picks the action for each item and sequences the datapath.
module tbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  tbs_pkg::dp_stat_t   dp_stat,
  output tbs_pkg::dp_cmd_t    dp_cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LEN,
    ST_START,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_t;

  state_t          state;
  tbs_pkg::act_t   act;
  tbs_pkg::act_t   act_next;
  logic            load_out;

  always_comb begin
    act_next = tbs_pkg::ACT_NONE;
    case (dp_stat.cmd)
      tbs_pkg::CMD_TICK: begin
        if (!dp_stat.packet_held || !dp_stat.tx_en) begin
          act_next = tbs_pkg::ACT_NONE;
        end else if (dp_stat.bursting) begin
          if (dp_stat.burst_due) begin
            act_next = dp_stat.trickle ? tbs_pkg::ACT_END_TRICKLE : tbs_pkg::ACT_END_BASIC;
          end
        end else if (dp_stat.tx_due) begin
          if (dp_stat.trickle && dp_stat.awaiting) begin
            act_next = tbs_pkg::ACT_DOUBLE;
          end else if (dp_stat.trickle && dp_stat.supp_hit) begin
            act_next = tbs_pkg::ACT_SUPPRESS;
          end else begin
            act_next = tbs_pkg::ACT_BURST;
          end
        end
      end
      tbs_pkg::CMD_NEW_STATE:
        act_next = dp_stat.trickle ? tbs_pkg::ACT_NEW_TRICKLE : tbs_pkg::ACT_NEW_BASIC;
      tbs_pkg::CMD_CONSISTENT: act_next = tbs_pkg::ACT_CONSIST;
      tbs_pkg::CMD_INCONSISTENT:
        act_next = dp_stat.trickle ? tbs_pkg::ACT_RESTART : tbs_pkg::ACT_NONE;
      tbs_pkg::CMD_CLEAR: act_next = tbs_pkg::ACT_CLEAR;
      default: act_next = tbs_pkg::ACT_NONE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign load_out = (state == ST_OUT) && (!m_tvalid || m_tready);

  assign dp_cmd.latch_in  = s_tvalid && s_tready;
  assign dp_cmd.upd_len   = (state == ST_LEN);
  assign dp_cmd.div_start = (state == ST_START);
  assign dp_cmd.apply     = (state == ST_APPLY);
  assign dp_cmd.load_out  = load_out;
  assign dp_cmd.act       = act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      act      <= tbs_pkg::ACT_NONE;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          act   <= act_next;
          state <= ST_LEN;
        end
        ST_LEN: state <= tbs_pkg::act_uses_div(act) ? ST_START : ST_APPLY;
        ST_START: state <= ST_DIV;
        ST_DIV: begin
          if (dp_stat.div_done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: state <= ST_OUT;
        ST_OUT: begin
          // hold the result here until the output register is free
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_DECIDE)
    else $error("accepted transfer not decided");
  a_apply_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |=> state == ST_OUT && !s_tready)
    else $error("apply not followed by result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && m_tvalid && !m_tready |=> state == ST_OUT && m_tvalid)
    else $error("result dropped while output stalled");
`endif

endmodule

// ----- hw/rtl/trickle_broadcast_scheduler.sv -----
// Top level of the trickle broadcast scheduler: controller, datapath and port packing.
//
// Usage: each input transfer on the s_ group carries a command (tick, new state,
// consistent heard, inconsistent heard, clear), the current millisecond time and a
// random word. Every input transfer produces exactly one result transfer on the m_
// group: the event code, the current interval length, the next transmit time and
// the burst flag, all showing the state after the command.
// Configuration goes through cfg_wr_en / cfg_index / cfg_data, one register per
// cycle, and must be written only while no item is in flight; the block itself
// does not enforce this. Commands that need a random pick (interval start,
// basic-mode burst end) pass through the iterative remainder unit, the others skip
// it. One item is in work at a time; s_tready rises again once the result sits
// in the output register.
// Reset (rst, synchronous) returns registers and scheduler state to defaults and
// empties the output register. When the receiver stalls, the result is held in the
// output register; the next item may be accepted and worked on, and waits for the
// output register before completing.
module trickle_broadcast_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // command[2:0], now_ms[34:3], random_word[66:35], zero fill[71:67]
  input  logic [tbs_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // event_res[2:0], interval_now_ms[26:3], next_transmit_ms[58:27],
  // burst_active[59], zero fill[63:60]
  output logic [tbs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_wr_en,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int OUT_USED = tbs_pkg::EVT_W + tbs_pkg::LEN_W + tbs_pkg::TIME_W + 1;

  tbs_pkg::dp_cmd_t                dp_cmd;
  tbs_pkg::dp_stat_t               dp_stat;
  logic [tbs_pkg::EVT_W-1:0]       out_event;
  logic [tbs_pkg::LEN_W-1:0]       out_interval;
  logic [tbs_pkg::TIME_W-1:0]      out_next;
  logic                            out_burst;

  tbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  tbs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_command   (s_tdata[2:0]),
    .in_now       (s_tdata[34:3]),
    .in_random    (s_tdata[66:35]),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .out_event    (out_event),
    .out_interval (out_interval),
    .out_next     (out_next),
    .out_burst    (out_burst)
  );

  assign m_tdata = {{(tbs_pkg::OUT_DATA_W-OUT_USED){1'b0}},
                    out_burst, out_next, out_interval, out_event};

endmodule
